// ----- sv/tsm_pkg.sv -----
// Package: beat types and constants for the MPEG-4 start code scanner.
package tsm_pkg;

  localparam logic [7:0] PKT_LEN         = 8'd188;
  localparam logic [7:0] ELIG_OFFSET     = 8'd4;
  localparam logic [7:0] UNIT_OFFSET     = 8'd1;
  localparam logic [7:0] CODE_SEQ        = 8'hB0;
  localparam logic [7:0] CODE_VOL        = 8'h20;
  localparam logic [7:0] CODE_VOL_MASK   = 8'hF0;
  localparam logic [7:0] CODE_GOV        = 8'hB3;
  localparam logic [7:0] CODE_VOP        = 8'hB6;
  localparam logic [7:0] UNIT_START_MASK = 8'h40;
  localparam logic [7:0] NO_TYPE         = 8'hFF;

  localparam int unsigned FLAG_SEQ = 3;
  localparam int unsigned FLAG_VOL = 2;
  localparam int unsigned FLAG_GOV = 1;
  localparam int unsigned FLAG_VOP = 0;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] vop_type;
    logic [3:0] header_flags;
  } out_t;

endpackage

// ----- sv/ts_mpeg4_start_code_scanner_top.sv -----
// Top level of the transport stream MPEG-4 start code scanner.
// One byte per beat, one beat per cycle unless stalled: a byte is registered on
// input and folded into the scan state from there; a buffer's result is
// registered as its last byte is folded in. The input stalls only when a last
// byte sits in the input register and the previous result has not been taken.
module ts_mpeg4_start_code_scanner_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  tsm_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output tsm_pkg::out_t out_data
);
  import tsm_pkg::*;

  logic            stage_valid;
  in_t             stage;
  logic            blocked;
  logic            advance;

  logic [3:0][7:0] byte_window;
  logic [3:0]      elig_window;
  logic [7:0]      packet_offset;
  logic            unit_start_bit;
  logic [3:0]      flags_accum;
  logic [7:0]      type_found;
  logic            type_pending;

  logic [3:0][7:0] byte_window_next;
  logic [3:0]      elig_window_next;
  logic            unit_start_next;
  logic            elig;
  logic [7:0]      type_next;
  logic [3:0]      hit;
  logic [3:0]      flags_next;

  assign blocked  = stage_valid && stage.last_byte && out_valid && out_stall;
  assign in_stall = blocked;
  assign advance  = stage_valid && !blocked;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!blocked) begin
      stage_valid <= in_valid;
    end
    if (!blocked && in_valid) begin
      stage <= in_data;
    end
  end

  always_comb begin
    type_next       = type_pending ? {6'd0, stage.data_byte[7:6]} : type_found;
    unit_start_next = (packet_offset == UNIT_OFFSET)
                      ? ((stage.data_byte & UNIT_START_MASK) != 8'h00) : unit_start_bit;
    elig            = (packet_offset >= ELIG_OFFSET) && unit_start_next;
    byte_window_next = {stage.data_byte, byte_window[3], byte_window[2], byte_window[1]};
    elig_window_next = {elig, elig_window[3], elig_window[2], elig_window[1]};
  end

  tsm_detect u_detect (
    .window (byte_window_next),
    .elig   (elig_window_next[0]),
    .hit    (hit)
  );

  assign flags_next = flags_accum | hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_window    <= '0;
      elig_window    <= '0;
      packet_offset  <= '0;
      unit_start_bit <= 1'b0;
      flags_accum    <= '0;
      type_found     <= NO_TYPE;
      type_pending   <= 1'b0;
    end else if (advance) begin
      if (stage.last_byte) begin
        byte_window    <= '0;
        elig_window    <= '0;
        packet_offset  <= '0;
        unit_start_bit <= 1'b0;
        flags_accum    <= '0;
        type_found     <= NO_TYPE;
        type_pending   <= 1'b0;
      end else begin
        byte_window    <= byte_window_next;
        elig_window    <= elig_window_next;
        packet_offset  <= (packet_offset == PKT_LEN - 8'd1) ? 8'd0 : packet_offset + 8'd1;
        unit_start_bit <= unit_start_next;
        flags_accum    <= flags_next;
        type_found     <= type_next;
        type_pending   <= hit[FLAG_VOP];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && stage.last_byte) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (advance && stage.last_byte) begin
      out_data.vop_type     <= type_next;
      out_data.header_flags <= flags_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_offset_range: assert property (@(posedge clk) disable iff (rst)
    packet_offset < PKT_LEN)
    else $error("packet offset out of range");

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    advance && stage.last_byte |=> out_valid)
    else $error("no result after last byte");

  a_buffer_end_clears: assert property (@(posedge clk) disable iff (rst)
    advance && stage.last_byte |=> flags_accum == 4'd0 && type_found == NO_TYPE
      && packet_offset == 8'd0 && !type_pending)
    else $error("scan state not cleared at buffer end");

  a_type_needs_vop: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.vop_type != NO_TYPE |-> out_data.header_flags[FLAG_VOP])
    else $error("frame type without VOP flag");

  a_type_range: assert property (@(posedge clk) disable iff (rst)
    type_found != NO_TYPE |-> type_found[7:2] == 6'd0)
    else $error("frame type out of range");
`endif

endmodule

// ----- sv/tsm_detect.sv -----
// Start code compare over the four-byte window.
module tsm_detect (
  input  logic [3:0][7:0] window,
  input  logic            elig,
  output logic [3:0]      hit
);
  import tsm_pkg::*;

  logic prefix;

  assign prefix = elig && (window[0] == 8'h00) && (window[1] == 8'h00)
                  && (window[2] == 8'h01);

  always_comb begin
    hit           = '0;
    hit[FLAG_SEQ] = prefix && (window[3] == CODE_SEQ);
    hit[FLAG_VOL] = prefix && ((window[3] & CODE_VOL_MASK) == CODE_VOL);
    hit[FLAG_GOV] = prefix && (window[3] == CODE_GOV);
    hit[FLAG_VOP] = prefix && (window[3] == CODE_VOP);
  end

endmodule
